@@ sv/lfrg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfrg_pkg
// Shared types and constants for the lagged Fibonacci generator.
// ----------------------------------------------------------------------------
package lfrg_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);

  // lags behind the write position
  localparam int unsigned LAG_A = 24;
  localparam int unsigned LAG_B = 55;
  localparam int unsigned LAG_C = 61;

  // reseed congruential chain
  localparam logic [WORD_W-1:0] LCG_MULT = 32'd67397;
  localparam logic [WORD_W-1:0] LCG_INC  = 32'd7364893;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } fill_state_t;

  typedef struct packed {
    logic  busy;
    logic  shift;
    word_t word;
  } fill_t;

endpackage : lfrg_pkg
`default_nettype wire

@@ sv/lfrg_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfrg_cell
// One word of the lag ring; takes its input word (the neighbor's, or the new word at the head) on each shift.
// ----------------------------------------------------------------------------
module lfrg_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           shift_en,
  input  wire lfrg_pkg::word_t d_in,
  output lfrg_pkg::word_t      q
);
  import lfrg_pkg::*;

  word_t word_r;
  word_t word_nxt;

  always_comb begin
    word_nxt = shift_en ? d_in : word_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign q = word_r;

endmodule : lfrg_cell
`default_nettype wire

@@ sv/lfrg_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfrg_seq
// Reseed sequencer: runs the congruential chain and feeds one word per cycle
// into the head of the ring.
// ----------------------------------------------------------------------------
module lfrg_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire lfrg_pkg::word_t seed,
  output lfrg_pkg::fill_t      fill
);
  import lfrg_pkg::*;

  fill_state_t      state_r;
  fill_state_t      state_nxt;
  word_t            x_r;
  word_t            x_nxt;
  logic [IDX_W-1:0] cnt_r;
  logic [IDX_W-1:0] cnt_nxt;
  word_t            lcg_val;

  assign lcg_val = x_r * LCG_MULT + LCG_INC;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (cnt_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    x_nxt   = x_r;
    cnt_nxt = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          x_nxt   = seed;
          cnt_nxt = '0;
        end
      end
      ST_FILL: begin
        x_nxt   = lcg_val;
        cnt_nxt = cnt_r + 1'b1;
      end
      default: begin
        x_nxt   = x_r;
        cnt_nxt = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    fill.busy  = (state_r == ST_FILL);
    fill.shift = (state_r == ST_FILL);
    fill.word  = lcg_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

`ifndef NO_ASSERTIONS
  a_start_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> (state_r == ST_FILL && cnt_r == '0))
    else $error("reseed did not enter fill with cleared count");

  a_fill_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && cnt_r == IDX_W'(DEPTH - 1)) |=> (state_r == ST_IDLE))
    else $error("fill did not end after a full ring");
`endif

endmodule : lfrg_seq
`default_nettype wire

@@ sv/lagged_fibonacci_random_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lagged_fibonacci_random_generator
// Parisi-Rapuano lagged generator on a 256-word shifting ring.
// ----------------------------------------------------------------------------
// A next request (func 0) forms the new word from fixed taps of the ring and
// shifts it in, and a request can follow every cycle while the output is
// taken. A reseed request (func 1) returns 0 without waiting for the fill and
// holds off new requests while the congruential chain, one multiply per
// cycle, shifts 256 fresh words into the ring. The ring is cleared to zero by
// reset, so it yields only zero words until a reseed fills it.
module lagged_fibonacci_random_generator (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire logic  in_func,
  input  wire logic [31:0] in_seed,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [31:0] out_random_word
);
  import lfrg_pkg::*;

  fill_t  fill;
  word_t  ring_q [DEPTH];
  word_t  head_d;
  word_t  sum_w;
  logic   in_acc;
  logic   next_acc;
  logic   seed_acc;
  logic   shift_en;
  logic   out_valid_r;
  logic   out_valid_nxt;
  word_t  out_word_r;
  word_t  out_word_nxt;

  assign in_stall = fill.busy || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign next_acc = in_acc && !in_func;
  assign seed_acc = in_acc && in_func;

  lfrg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seed_acc),
    .seed  (in_seed),
    .fill  (fill)
  );

  // ring_q[k] holds the word shifted in k+1 shifts ago
  assign sum_w    = ring_q[LAG_A - 1] + ring_q[LAG_B - 1];
  assign head_d   = fill.shift ? fill.word : sum_w;
  assign shift_en = fill.shift || next_acc;

  for (genvar k = 0; k < DEPTH; k++) begin : g_ring
    if (k == 0) begin : g_head
      lfrg_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_in     (head_d),
        .q        (ring_q[k])
      );
    end else begin : g_body
      lfrg_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_in     (ring_q[k-1]),
        .q        (ring_q[k])
      );
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = in_func ? '0 : (sum_w ^ ring_q[LAG_C - 1]);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

`ifndef NO_ASSERTIONS
  a_seed_result: assert property (@(posedge clk) disable iff (!rst_n)
    seed_acc |=> (out_valid_r && out_word_r == '0))
    else $error("reseed request did not yield a zero result");

  a_no_mixed_shift: assert property (@(posedge clk) disable iff (!rst_n)
    fill.shift |-> !next_acc)
    else $error("next request taken during ring fill");
`endif

endmodule : lagged_fibonacci_random_generator
`default_nettype wire
